[rtl/integer_to_radix_text_macros.svh]
// integer_to_radix_text_macros.svh: assertion macros used by the RTL top level.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ITRT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer_to_radix_text: assertion failed");

// Next-cycle implication, disabled while reset is high
`define ITRT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer_to_radix_text: assertion failed");

`endif

[rtl/itrt_pkg.sv]
// itrt_pkg: constants, types and helpers for the radix text converter.
// Used by itrt_ctrl, itrt_datapath and integer_to_radix_text.
package itrt_pkg;

   // Sizes
   localparam int MAX_BASE    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int INPUT_BITS  = 32;
   localparam int ALPHA_SYMS  = 16;
   localparam int ALPHA_BITS  = ALPHA_SYMS * 8;
   localparam int WORD_BITS   = 64;
   localparam int LEN_BITS    = 5;
   localparam int DIGIT_BITS  = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
   localparam int REM_BITS    = DIGIT_BITS + 1;
   localparam int DIV_BITS    = 8;
   localparam int DIV_ROUNDS  = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int WORK_BITS   = DIV_ROUNDS * DIV_BITS;
   localparam int ROUND_BITS  = (DIV_ROUNDS > 1) ? $clog2(DIV_ROUNDS) : 1;
   localparam int COUNT_BITS  = $clog2(VALUE_BITS + 1);
   localparam int STACK_BITS  = VALUE_BITS * DIGIT_BITS;

   // Character codes
   localparam logic [7:0] SYM_MIN   = 8'd33;
   localparam logic [7:0] SYM_MAX   = 8'd126;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;

   // Register indexes
   localparam logic [1:0] CSR_ALPHABET_LOW    = 2'd0;
   localparam logic [1:0] CSR_ALPHABET_HIGH   = 2'd1;
   localparam logic [1:0] CSR_ALPHABET_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic show_sign;
      logic show_digit;
      logic pop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic alpha_ok;
      logic final_round;
      logic quot_zero;
      logic count_one;
      logic neg;
   } dp_status_type;

   // Pick symbol idx out of the packed alphabet, symbol 0 in the lowest byte
   function automatic logic [7:0] symbol_at(input logic [ALPHA_BITS-1:0] alpha,
                                            input logic [DIGIT_BITS-1:0] idx);
      return alpha[{idx, 3'b000} +: 8];
   endfunction

endpackage

[rtl/integer_to_radix_text.sv]
// integer_to_radix_text: top level of the signed integer to radix text converter.
// Depends on itrt_pkg, itrt_ctrl, itrt_datapath and integer_to_radix_text_macros.svh.
//
//   channel   ports                                  handshake
//   input     req_value                              start high while busy low
//   result    rsp_symbol, rsp_last                   rsp_valid, one cycle each
//   config    csr_index, csr_data                    csr_write high
//
// An item is accepted, its alphabet is checked, then each digit is worked out in the
// divider (8 quotient bits per cycle over the 32-bit magnitude), then the characters go
// out one per cycle, with a minus sign first for a negative value.
// A bad alphabet ends the item after the check cycle with no characters.
// Reset is synchronous and clears the config registers and the sequencer.
// Results cannot be stalled; one item is worked on at a time.
`include "integer_to_radix_text_macros.svh"

module integer_to_radix_text (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [itrt_pkg::INPUT_BITS-1:0]   req_value,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_symbol,
   output logic                              rsp_last,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [itrt_pkg::WORD_BITS-1:0]    csr_data
);
   import itrt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   itrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Registers, check, divider and output
   itrt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

   // Checks
   `ITRT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ITRT_ASSERT_IMP(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   `ITRT_ASSERT_NXT(a_last_ends_item, clock, reset, rsp_valid && rsp_last, !busy)

endmodule

[rtl/itrt_ctrl.sv]
// itrt_ctrl: sequencer for one conversion (check, divide, emit).
// Depends on itrt_pkg; drives itrt_datapath through ctrl_cmd_type.
module itrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  itrt_pkg::dp_status_type status,
   output itrt_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import itrt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // bad alphabet: item gives no results
            state_in = status.alpha_ok ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.final_round && status.quot_zero) begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.show_sign = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.show_digit = 1'b1;
            cmd.pop        = 1'b1;
            if (status.count_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = cmd.show_sign | cmd.show_digit;

endmodule

[rtl/itrt_datapath.sv]
// itrt_datapath: config registers, alphabet check, digit divider and digit stack.
// Depends on itrt_pkg; commanded by itrt_ctrl.
module itrt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [1:0]                           csr_index,
   input  logic [itrt_pkg::WORD_BITS-1:0]       csr_data,
   input  logic [itrt_pkg::INPUT_BITS-1:0]      req_value,
   input  itrt_pkg::ctrl_cmd_type               cmd,
   output itrt_pkg::dp_status_type              status,
   output logic [7:0]                           rsp_symbol,
   output logic                                 rsp_last
);
   import itrt_pkg::*;

   logic [WORD_BITS-1:0]  alpha_low_ff;
   logic [WORD_BITS-1:0]  alpha_high_ff;
   logic [LEN_BITS-1:0]   alpha_len_ff;
   logic [ALPHA_BITS-1:0] alpha;

   logic [WORK_BITS-1:0]  work_ff,  work_in;
   logic [REM_BITS-1:0]   rem_ff,   rem_in;
   logic [ROUND_BITS-1:0] round_ff, round_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [STACK_BITS-1:0] stack_ff, stack_in;
   logic                  neg_ff,   neg_in;

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic [REM_BITS-1:0]   radix;
   logic [WORK_BITS-1:0]  step_work;
   logic [REM_BITS-1:0]   step_rem;
   logic                  final_round;
   logic                  sym_bad;
   logic                  alpha_ok;
   logic [7:0]            sym_i;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         alpha_len_ff  <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_ALPHABET_LOW) begin
            alpha_low_ff <= csr_data;
         end
         if (csr_index == CSR_ALPHABET_HIGH) begin
            alpha_high_ff <= csr_data;
         end
         if (csr_index == CSR_ALPHABET_LENGTH) begin
            alpha_len_ff <= csr_data[LEN_BITS-1:0];
         end
      end
   end

   assign alpha = {alpha_high_ff, alpha_low_ff};
   assign radix = alpha_len_ff[REM_BITS-1:0];

   // Alphabet check: length, range, sign characters and duplicates, all in parallel
   always_comb begin
      sym_bad = 1'b0;
      for (int i = 0; i < MAX_BASE; i++) begin
         sym_i = alpha[i*8 +: 8];
         if (LEN_BITS'(i) < alpha_len_ff) begin
            if (sym_i < SYM_MIN || sym_i > SYM_MAX ||
                sym_i == SYM_PLUS || sym_i == SYM_MINUS) begin
               sym_bad = 1'b1;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (LEN_BITS'(j) < alpha_len_ff && alpha[j*8 +: 8] == sym_i) begin
                  sym_bad = 1'b1;
               end
            end
         end
      end
      alpha_ok = (alpha_len_ff >= LEN_BITS'(2)) &&
                 (alpha_len_ff <= LEN_BITS'(MAX_BASE)) && !sym_bad;
   end

   // Magnitude of the low VALUE_BITS bits as two's complement
   assign raw = req_value[VALUE_BITS-1:0];
   assign mag = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;

   // One round of long division: DIV_BITS restoring steps on a narrow remainder
   always_comb begin
      step_work = work_ff;
      step_rem  = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         step_rem  = {step_rem[DIGIT_BITS-1:0], step_work[WORK_BITS-1]};
         step_work = {step_work[WORK_BITS-2:0], 1'b0};
         if (step_rem >= radix) begin
            step_rem     = step_rem - radix;
            step_work[0] = 1'b1;
         end
      end
   end

   assign final_round = (round_ff == ROUND_BITS'(DIV_ROUNDS - 1));

   // Next values of the divider and the digit stack
   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      round_in = round_ff;
      count_in = count_ff;
      stack_in = stack_ff;
      neg_in   = neg_ff;
      if (cmd.load) begin
         work_in  = WORK_BITS'(mag);
         rem_in   = '0;
         round_in = '0;
         count_in = '0;
         neg_in   = raw[VALUE_BITS-1];
      end else if (cmd.div_step) begin
         work_in = step_work;
         if (final_round) begin
            // digit done: push it, restart on the quotient
            rem_in   = '0;
            round_in = '0;
            count_in = count_ff + COUNT_BITS'(1);
            stack_in = {stack_ff[STACK_BITS-DIGIT_BITS-1:0], step_rem[DIGIT_BITS-1:0]};
         end else begin
            rem_in   = step_rem;
            round_in = round_ff + ROUND_BITS'(1);
         end
      end else if (cmd.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
         stack_in = {{DIGIT_BITS{1'b0}}, stack_ff[STACK_BITS-1:DIGIT_BITS]};
      end
   end

   // Control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         count_ff <= '0;
      end else begin
         round_ff <= round_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      stack_ff <= stack_in;
      neg_ff   <= neg_in;
   end

   // Status to the controller
   assign status.alpha_ok    = alpha_ok;
   assign status.final_round = final_round;
   assign status.quot_zero   = (step_work == '0);
   assign status.count_one   = (count_ff == COUNT_BITS'(1));
   assign status.neg         = neg_ff;

   // Result characters: sign, then digits from the top of the stack
   assign rsp_symbol = cmd.show_sign ? SYM_MINUS
                                     : symbol_at(alpha, stack_ff[DIGIT_BITS-1:0]);
   assign rsp_last   = cmd.show_digit && (count_ff == COUNT_BITS'(1));

endmodule

[bench/itrt_text_checker.sv]
// itrt_text_checker: watches the converter's item, result and register ports,
// predicts the text of each accepted value and compares it character by character.
// Depends on itrt_pkg only; instantiated beside the block by tb_integer_to_radix_text.
`timescale 1ns / 1ps

module itrt_text_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [itrt_pkg::INPUT_BITS-1:0]   req_value,
   input  logic                              rsp_valid,
   input  logic [7:0]                        rsp_symbol,
   input  logic                              rsp_last,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [itrt_pkg::WORD_BITS-1:0]    csr_data,
   output logic [31:0]                       fail_count,
   output logic [31:0]                       chars_pending
);
   import itrt_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0]            symbol;
      logic                  last;
      logic [INPUT_BITS-1:0] source;
   } rendered_char_type;

   // Shadow copy of the alphabet registers
   logic [WORD_BITS-1:0] alpha_lo;
   logic [WORD_BITS-1:0] alpha_hi;
   logic [LEN_BITS-1:0]  alpha_len;

   rendered_char_type expected_chars[$];
   int failures = 0;

   assign fail_count = failures;

   function automatic logic [7:0] glyph(input logic [4:0] idx);
      logic [WORD_BITS-1:0] word;
      word = (idx < 8) ? alpha_lo : alpha_hi;
      return word[{idx[2:0], 3'b000} +: 8];
   endfunction

   // Length in 2..MAX_BASE, printable symbols, no signs, no repeats
   function automatic bit alphabet_valid();
      int i;
      int j;
      logic [7:0] s;
      if (alpha_len < 2 || alpha_len > MAX_BASE) return 1'b0;
      for (i = 0; i < alpha_len; i++) begin
         s = glyph(i[4:0]);
         if (s < SYM_MIN || s > SYM_MAX || s == SYM_PLUS || s == SYM_MINUS) return 1'b0;
         for (j = i + 1; j < alpha_len; j++)
            if (glyph(j[4:0]) == s) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Queue the characters one value should produce
   task automatic render_value(input logic [INPUT_BITS-1:0] v);
      logic                  neg;
      logic [31:0]           mag;
      logic [31:0]           rem;
      logic [7:0]            digits [0:VALUE_BITS-1];
      int                    count;
      int                    k;
      if (!alphabet_valid()) return;
      neg = v[VALUE_BITS-1];
      // magnitude of the most negative value still fits as unsigned
      mag = neg ? (32'd0 - v) : v;
      count = 0;
      do begin
         rem = mag % {27'd0, alpha_len};
         digits[count] = glyph(rem[4:0]);
         count++;
         mag = mag / {27'd0, alpha_len};
      end while (mag != 0 && count < VALUE_BITS);
      if (neg) expected_chars.push_back('{SYM_MINUS, 1'b0, v});
      for (k = count - 1; k >= 0; k--)
         expected_chars.push_back('{digits[k], k == 0, v});
   endtask

   task automatic note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t text check: %s", $time, what);
   endtask

   always @(posedge clock) begin : watch
      rendered_char_type want;
      if (reset) begin
         alpha_lo = '0;
         alpha_hi = '0;
         alpha_len = '0;
         expected_chars.delete();
      end else begin
         // results first: an item's characters never leave on its accept edge
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               note_failure($sformatf("unexpected char symbol 0x%02h last %0b",
                                      rsp_symbol, rsp_last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_symbol !== want.symbol)
                  note_failure($sformatf("value %0d: symbol expected 0x%02h got 0x%02h",
                                         $signed(want.source), want.symbol, rsp_symbol));
               if (rsp_last !== want.last)
                  note_failure($sformatf("value %0d: last expected %0b got %0b",
                                         $signed(want.source), want.last, rsp_last));
            end
         end
         if (start && !busy) render_value(req_value);
         // register writes; the spare index is ignored
         if (csr_write) begin
            case (csr_index)
               CSR_ALPHABET_LOW:    alpha_lo = csr_data;
               CSR_ALPHABET_HIGH:   alpha_hi = csr_data;
               CSR_ALPHABET_LENGTH: alpha_len = csr_data[LEN_BITS-1:0];
               default: ;
            endcase
         end
      end
      chars_pending <= expected_chars.size();
   end

endmodule

[bench/tb_integer_to_radix_text.sv]
// tb_integer_to_radix_text: drives values and alphabet settings into the radix text
// converter and gives the verdict. Depends on itrt_pkg, integer_to_radix_text and
// itrt_text_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_integer_to_radix_text;
   import itrt_pkg::*;

   localparam int         CYCLE_LIMIT  = 2000000;
   localparam int         DRAIN_CYCLES = 180;
   localparam int         RESET_CYCLES = 7;
   localparam int         RANDOM_ITEMS = 480;
   localparam logic [1:0] CSR_SPARE    = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic [INPUT_BITS-1:0] req_value = '0;
   logic                  csr_write = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [WORD_BITS-1:0]  csr_data  = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [7:0]            rsp_symbol;
   logic                  rsp_last;
   logic [31:0]           fail_count;
   logic [31:0]           chars_pending;

   int unsigned cycles = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b0;

   always #2 clock = ~clock;

   integer_to_radix_text dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   itrt_text_checker text_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_symbol    (rsp_symbol),
      .rsp_last      (rsp_last),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .chars_pending (chars_pending)
   );

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_put(input logic [1:0] idx, input logic [WORD_BITS-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
   endtask

   // Back-to-back register writes, junk above the length field
   task automatic load_alphabet(input logic [WORD_BITS-1:0] lo, hi,
                                input logic [LEN_BITS-1:0] len);
      logic [WORD_BITS-1:0] len_word;
      len_word = {$urandom(), $urandom()};
      len_word[LEN_BITS-1:0] = len;
      csr_put(CSR_ALPHABET_LOW, lo);
      csr_put(CSR_ALPHABET_HIGH, hi);
      if ($urandom_range(0, 1)) csr_put(CSR_SPARE, {$urandom(), $urandom()});
      csr_put(CSR_ALPHABET_LENGTH, len_word);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Hold one item until accepted; gaps open between bursts
   task automatic send_value(input logic [INPUT_BITS-1:0] v);
      if (gaps_on && burst_left == 0) begin
         start     <= 1'b0;
         req_value <= $urandom();
         repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 200)
                                              : $urandom_range(1, 8))
            @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      if (burst_left > 0) burst_left--;
   endtask

   // Let every expected char arrive, then cover items that emit nothing
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (chars_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void pack_text(input string text,
                                     output logic [WORD_BITS-1:0] lo,
                                     output logic [WORD_BITS-1:0] hi);
      int i;
      lo = {$urandom(), $urandom()};
      hi = {$urandom(), $urandom()};
      for (i = 0; i < text.len() && i < ALPHA_SYMS; i++) begin
         if (i < 8) lo[i*8 +: 8] = text[i];
         else hi[(i-8)*8 +: 8] = text[i];
      end
   endfunction

   // Random alphabet; about one in five is broken in one way
   task automatic pick_alphabet(output logic [WORD_BITS-1:0] lo, hi,
                                output logic [LEN_BITS-1:0] len, output bit ok);
      logic [7:0] glyphs [0:ALPHA_SYMS-1];
      bit         used [0:255];
      int         i;
      int         pos;
      int         other;
      for (i = 0; i < 256; i++) used[i] = 1'b0;
      for (i = 0; i < ALPHA_SYMS; i++) begin
         do glyphs[i] = $urandom_range(SYM_MIN, SYM_MAX);
         while (used[glyphs[i]] || glyphs[i] == SYM_PLUS || glyphs[i] == SYM_MINUS);
         used[glyphs[i]] = 1'b1;
      end
      case ($urandom_range(0, 3))
         0:       len = 2;
         1:       len = MAX_BASE;
         default: len = $urandom_range(2, MAX_BASE);
      endcase
      // bytes past the length are never checked
      for (i = len; i < ALPHA_SYMS; i++)
         if ($urandom_range(0, 1)) glyphs[i] = $urandom();
      ok = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
         ok  = 1'b0;
         pos = $urandom_range(0, len - 1);
         case ($urandom_range(0, 6))
            0: len = $urandom_range(0, 1);
            1: len = $urandom_range(MAX_BASE + 1, 31);
            2: glyphs[pos] = $urandom_range(0, SYM_MIN - 1);
            3: glyphs[pos] = $urandom_range(SYM_MAX + 1, 255);
            4: glyphs[pos] = SYM_PLUS;
            5: glyphs[pos] = SYM_MINUS;
            default: begin
               other = (pos + 1 + $urandom_range(0, len - 2)) % len;
               glyphs[pos] = glyphs[other];
            end
         endcase
      end
      for (i = 0; i < ALPHA_SYMS; i++) begin
         if (i < 8) lo[i*8 +: 8] = glyphs[i];
         else hi[(i-8)*8 +: 8] = glyphs[i];
      end
   endtask

   // Mix of full range, short, extreme and power-of-radix values
   function automatic logic [INPUT_BITS-1:0] pick_value(input logic [LEN_BITS-1:0] radix);
      logic [63:0] power;
      int          steps;
      case ($urandom_range(0, 7))
         0, 1: return $urandom();
         2:    return $urandom_range(0, 300);
         3:    return 32'd0 - $urandom_range(1, 300);
         4: begin
            case ($urandom_range(0, 4))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'hffff_ffff;
               3:       return 32'd0;
               default: return 32'd1;
            endcase
         end
         5: begin
            power = 1;
            steps = $urandom_range(1, 31);
            while (steps > 0 && power * radix <= 64'h7fff_ffff) begin
               power = power * radix;
               steps--;
            end
            power = power - $urandom_range(0, 1);
            if ($urandom_range(0, 1)) power = 64'd0 - power;
            return power[31:0];
         end
         default: return $signed($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   initial begin
      logic [WORD_BITS-1:0]  lo;
      logic [WORD_BITS-1:0]  hi;
      logic [LEN_BITS-1:0]   len;
      bit                    ok;
      int                    count;
      int                    valid_items;
      int                    k;
      logic [INPUT_BITS-1:0] hex_values [0:8];
      string                 bad_text [0:8];
      int                    bad_len [0:8];

      hex_values = '{32'd0, 32'd1, 32'hffff_ffff,
                     32'h7fff_ffff, 32'h8000_0000, 32'd15,
                     32'd16, 32'hffff_fff0, 32'hdead_beef};
      bad_text   = '{"0123456789ABCDEA", "01+3", "0-", " 1",
                     "0\177", "0123456789ABCDEF",
                     "0123456789ABCDEF", "0123456789ABCDEF",
                     "0123456789ABCDEF"};
      bad_len    = '{16, 4, 2, 2, 2, 1, 0, 17, 31};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Hex: zero, one, extremes, digit rollover
      pack_text("0123456789ABCDEF", lo, hi);
      load_alphabet(lo, hi, 16);
      for (k = 0; k < 9; k++) send_value(hex_values[k]);
      wait_idle();

      // Binary with the outermost printable symbols: longest texts
      pack_text("!~", lo, hi);
      load_alphabet(lo, hi, 2);
      send_value(32'h8000_0000);
      send_value(32'h7fff_ffff);
      send_value(32'd0);
      send_value(32'hffff_ffff);
      wait_idle();

      // Decimal, junk in unused bytes
      pack_text("0123456789", lo, hi);
      load_alphabet(lo, hi, 10);
      send_value(32'h8000_0000);
      send_value(32'd123456789);
      send_value(32'hffff_fff6);
      wait_idle();

      // Broken alphabets: repeat, plus, minus, space, DEL, too short, too long
      for (k = 0; k < 9; k++) begin
         pack_text(bad_text[k], lo, hi);
         load_alphabet(lo, hi, bad_len[k]);
         send_value($urandom());
         wait_idle();
      end

      // Random phases
      valid_items = 0;
      while (valid_items < RANDOM_ITEMS) begin
         pick_alphabet(lo, hi, len, ok);
         load_alphabet(lo, hi, len);
         gaps_on    = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         count      = ok ? $urandom_range(5, 40) : $urandom_range(1, 4);
         repeat (count) send_value(pick_value(len));
         if (ok) valid_items += count;
         wait_idle();
      end

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/itrt_pkg.sv
rtl/itrt_ctrl.sv
rtl/itrt_datapath.sv
rtl/integer_to_radix_text.sv
bench/itrt_text_checker.sv
bench/tb_integer_to_radix_text.sv
